>>> rtl/iqfr_pkg.sv
// Shared constants, codes and types of the I/Q fractional resampler.
package iqfr_pkg;

  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int PHASE_FRAC_BITS_DEF = 16;
  localparam int MAX_OUT_PER_IN_DEF  = 4;

  // Integer bits above the binary point of the phase accumulator and step.
  localparam int PHASE_INT_BITS = 3;

  // Entries of each decoupling queue.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic CFG_IDX_MODE = 1'b0;
  localparam logic CFG_IDX_STEP = 1'b1;

  // Interpolation mode codes.
  localparam logic MODE_NEAREST = 1'b0;
  localparam logic MODE_LINEAR  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } iqfr_state_t;

endpackage

>>> rtl/iqfr_fifo.sv
// Small register queue used between the front, the back and the result port.
module iqfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/iqfr_front.sv
// Front end: accept samples, mark those that only load the history.
module iqfr_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  input  logic [SAMPLE_BITS-1:0]   in_i,
  input  logic [SAMPLE_BITS-1:0]   in_q,
  input  logic                     in_block_start,
  output logic                     in_full,
  output logic                     mid_push,
  output logic [2*SAMPLE_BITS:0]   mid_data,
  input  logic                     mid_full
);

  import iqfr_pkg::*;

  logic have_prev_r, have_prev_nxt;
  logic store_only;

  // A block start, or the first sample after reset, only loads the history.
  assign store_only = in_block_start || !have_prev_r;
  assign in_full    = mid_full;
  assign mid_push   = in_push && !mid_full;
  assign mid_data   = {store_only, in_i, in_q};

  always_comb begin
    have_prev_nxt = have_prev_r;
    if (mid_push) begin
      have_prev_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else begin
      have_prev_r <= have_prev_nxt;
    end
  end

endmodule

>>> rtl/iqfr_back.sv
// Back end: phase accumulator loop and the interpolation datapath.
module iqfr_back #(
  parameter int SAMPLE_BITS     = 16,
  parameter int PHASE_FRAC_BITS = 16,
  parameter int MAX_OUT_PER_IN  = 4
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              cfg_mode,
  input  logic [PHASE_FRAC_BITS+iqfr_pkg::PHASE_INT_BITS-1:0] cfg_step,
  input  logic                                              mid_empty,
  input  logic [2*SAMPLE_BITS:0]                            mid_data,
  output logic                                              mid_pop,
  input  logic                                              out_full,
  output logic                                              out_push,
  output logic [2*SAMPLE_BITS:0]                            out_data
);

  import iqfr_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int FB = PHASE_FRAC_BITS;
  localparam int PW = FB + PHASE_INT_BITS;
  localparam int CW = $clog2(MAX_OUT_PER_IN + 1);
  localparam logic [CW-1:0]      CNT_MAX = CW'(MAX_OUT_PER_IN);
  localparam logic [PW-1:0]      ONE_P   = {{(PHASE_INT_BITS-1){1'b0}}, 1'b1, {FB{1'b0}}};
  localparam logic [FB-1:0]      HALF_F  = {1'b1, {(FB-1){1'b0}}};
  localparam logic [SB+FB+1:0]   HALF_P  = {{(SB+2){1'b0}}, HALF_F};

  iqfr_state_t   state_r, state_nxt;
  logic [PW-1:0] phase_r, phase_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SB-1:0] prev_i_r, prev_i_nxt, prev_q_r, prev_q_nxt;
  logic [SB-1:0] cur_i_r, cur_i_nxt, cur_q_r, cur_q_nxt;
  logic          mid_store;
  logic [SB-1:0] mid_i, mid_q;
  logic          below_one;
  logic [PW-1:0] phase_sum;
  logic          is_last;
  logic [SB-1:0] res_i, res_q;

  function automatic logic [PW-1:0] wrap_phase(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = '0;
    if (p[PW-1:FB] != '0) begin
      r = p - ONE_P;
    end
    return r;
  endfunction

  function automatic logic [SB-1:0] interp(input logic [SB-1:0] a, input logic [SB-1:0] b,
                                           input logic [FB-1:0] f, input logic mode);
    logic signed [SB:0]      diff;
    logic signed [SB+FB+1:0] prod;
    logic [SB+1:0]           delta;
    logic [SB+1:0]           sum;
    logic [SB-1:0]           r;
    diff  = $signed({b[SB-1], b}) - $signed({a[SB-1], a});
    prod  = diff * $signed({1'b0, f}) + $signed(HALF_P);
    // Floor of the rounded product: keep the bits above the fraction.
    delta = prod[SB+FB+1:FB];
    sum   = {{2{a[SB-1]}}, a} + delta;
    if (mode == MODE_LINEAR) begin
      r = sum[SB-1:0];
    end else begin
      r = (f <= HALF_F) ? a : b;
    end
    return r;
  endfunction

  assign mid_store = mid_data[2*SB];
  assign mid_i     = mid_data[2*SB-1:SB];
  assign mid_q     = mid_data[SB-1:0];
  assign below_one = (phase_r[PW-1:FB] == '0);
  assign phase_sum = phase_r + cfg_step;
  assign is_last   = (phase_sum[PW-1:FB] != '0) || ((cnt_r + 1'b1) == CNT_MAX);
  assign res_i     = interp(prev_i_r, cur_i_r, phase_r[FB-1:0], cfg_mode);
  assign res_q     = interp(prev_q_r, cur_q_r, phase_r[FB-1:0], cfg_mode);
  assign out_data  = {is_last, res_i, res_q};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!mid_empty && !mid_store) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!below_one || (!out_full && is_last)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    mid_pop    = 1'b0;
    out_push   = 1'b0;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    prev_i_nxt = prev_i_r;
    prev_q_nxt = prev_q_r;
    cur_i_nxt  = cur_i_r;
    cur_q_nxt  = cur_q_r;
    case (state_r)
      ST_IDLE: begin
        if (!mid_empty) begin
          mid_pop = 1'b1;
          if (mid_store) begin
            prev_i_nxt = mid_i;
            prev_q_nxt = mid_q;
            phase_nxt  = '0;
          end else begin
            cur_i_nxt = mid_i;
            cur_q_nxt = mid_q;
            cnt_nxt   = '0;
          end
        end
      end
      ST_RUN: begin
        if (!below_one) begin
          // Decimate: no output, drop one sample of phase.
          phase_nxt  = wrap_phase(phase_r);
          prev_i_nxt = cur_i_r;
          prev_q_nxt = cur_q_r;
        end else if (!out_full) begin
          out_push  = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          phase_nxt = phase_sum;
          if (is_last) begin
            phase_nxt  = wrap_phase(phase_sum);
            prev_i_nxt = cur_i_r;
            prev_q_nxt = cur_q_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      phase_r  <= '0;
      cnt_r    <= '0;
      prev_i_r <= '0;
      prev_q_r <= '0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      prev_i_r <= prev_i_nxt;
      prev_q_r <= prev_q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_i_r <= cur_i_nxt;
    cur_q_r <= cur_q_nxt;
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full)
    else $error("result pushed into a full queue");

  a_cap_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (cnt_r < CNT_MAX))
    else $error("output count reached the cap while running");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_push && is_last) |=> (state_r == ST_IDLE))
    else $error("run continued after its final output");

  a_no_pop_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> !mid_pop)
    else $error("sample taken while a run is in progress");

endmodule

>>> rtl/iq_fractional_resampler_core.sv
// Top level of the I/Q fractional resampler: config registers, front, queues, back.
//
//  channel  direction  handshake           payload
//  in_      sink       in_push / in_full   in_i, in_q, in_block_start
//  out_     source     out_pop / out_empty out_i, out_q, out_run_last
//  cfg_     sink       cfg_we              cfg_index, cfg_wdata
//
// A sample that starts a block makes no result.
// Any other sample makes n results (n from 1 up to MAX_OUT_PER_IN) or none at
// all. The phase loop emits one result per cycle, while the result queue has
// room, through one multiplier per lane.
// rst_n is synchronous: it empties both queues and clears phase and history.
// A full result queue stalls the back end; the sample queue keeps accepting
// until it too is full.
module iq_fractional_resampler_core #(
  parameter int SAMPLE_BITS     = iqfr_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_FRAC_BITS = iqfr_pkg::PHASE_FRAC_BITS_DEF,
  parameter int MAX_OUT_PER_IN  = iqfr_pkg::MAX_OUT_PER_IN_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              cfg_we,
  input  logic                                              cfg_index,
  input  logic [PHASE_FRAC_BITS+iqfr_pkg::PHASE_INT_BITS-1:0] cfg_wdata,
  input  logic                                              in_push,
  output logic                                              in_full,
  input  logic [SAMPLE_BITS-1:0]                            in_i,
  input  logic [SAMPLE_BITS-1:0]                            in_q,
  input  logic                                              in_block_start,
  output logic                                              out_empty,
  input  logic                                              out_pop,
  output logic [SAMPLE_BITS-1:0]                            out_i,
  output logic [SAMPLE_BITS-1:0]                            out_q,
  output logic                                              out_run_last
);

  import iqfr_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int PW = PHASE_FRAC_BITS + PHASE_INT_BITS;
  // Step reset is 1.0: one output per input.
  localparam logic [PW-1:0] STEP_RESET = {{(PHASE_INT_BITS-1){1'b0}}, 1'b1,
                                          {PHASE_FRAC_BITS{1'b0}}};

  logic          mode_r, mode_nxt;
  logic [PW-1:0] step_r, step_nxt;

  logic          mid_push, mid_full, mid_pop, mid_empty;
  logic [2*SB:0] mid_wdata, mid_rdata;
  logic          res_push, res_full;
  logic [2*SB:0] res_wdata, res_rdata;

  // Configuration writes land directly; the user must make them only while the block is idle (not enforced).
  always_comb begin
    mode_nxt = mode_r;
    step_nxt = step_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_MODE: mode_nxt = cfg_wdata[0];
        CFG_IDX_STEP: step_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LINEAR;
      step_r <= STEP_RESET;
    end else begin
      mode_r <= mode_nxt;
      step_r <= step_nxt;
    end
  end

  // Front: classify each sample as history load or interpolation run.
  iqfr_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_i          (in_i),
    .in_q          (in_q),
    .in_block_start(in_block_start),
    .in_full       (in_full),
    .mid_push      (mid_push),
    .mid_data      (mid_wdata),
    .mid_full      (mid_full)
  );

  // Decouple the front from the phase loop.
  iqfr_fifo #(
    .WIDTH(2*SB + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (mid_push),
    .wdata(mid_wdata),
    .full (mid_full),
    .pop  (mid_pop),
    .rdata(mid_rdata),
    .empty(mid_empty)
  );

  // Back: walk the phase and interpolate one result per cycle while the result queue has room.
  iqfr_back #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS),
    .MAX_OUT_PER_IN (MAX_OUT_PER_IN)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_mode (mode_r),
    .cfg_step (step_r),
    .mid_empty(mid_empty),
    .mid_data (mid_rdata),
    .mid_pop  (mid_pop),
    .out_full (res_full),
    .out_push (res_push),
    .out_data (res_wdata)
  );

  // Result queue: holds finished transactions while the consumer stalls.
  iqfr_fifo #(
    .WIDTH(2*SB + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_wdata),
    .full (res_full),
    .pop  (out_pop),
    .rdata(res_rdata),
    .empty(out_empty)
  );

  assign out_run_last = res_rdata[2*SB];
  assign out_i        = res_rdata[2*SB-1:SB];
  assign out_q        = res_rdata[SB-1:0];

endmodule
